@@ rtl/lsh_pkg.sv @@
package lsh_pkg;

    localparam int HIST_BUCKETS_DEF = 32;
    localparam int SAMPLE_BITS_DEF  = 48;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int SAMPLE_W = 48;
    localparam int COUNT_W  = 32;
    localparam int TOTAL_W  = 63;
    localparam int MEAN_W   = 64;
    localparam int M2_W     = 64;
    localparam int BUCKET_W = 5;
    localparam int TALLY_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int HALF_W   = 32;
    localparam int PROD_W   = 2 * MEAN_W;

    localparam int NS_PER_US = 1000;

    localparam int DIV_STEPS = 2;
    localparam int DIV_ITERS = MEAN_W / DIV_STEPS;

endpackage

@@ rtl/lsh_front.sv @@
module lsh_front import lsh_pkg::*; #(
    parameter int HIST_BUCKETS = HIST_BUCKETS_DEF,
    parameter int SW           = SAMPLE_W,
    parameter int BW           = $clog2(HIST_BUCKETS_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [SAMPLE_W-1:0] i_sample_ns,
    output logic               o_full,
    output logic               o_q_push,
    output logic [SW+BW-1:0]   o_q_data,
    input  logic               i_q_full
);

    localparam int THR_W = SW + $clog2(NS_PER_US) + HIST_BUCKETS;

    logic          r_valid;
    logic [SW-1:0] r_sample;
    logic [BW-1:0] r_bucket;

    logic [SW-1:0]    w_sample;
    logic [THR_W-1:0] w_ext;
    logic [BW-1:0]    n_bucket;
    logic             w_accept;

    assign w_sample = i_sample_ns[SW-1:0];
    assign w_ext    = THR_W'(w_sample);

    // bucket b >= 1 starts at 1000 << b ns; bucket 0 holds everything below 2000 ns
    always_comb begin
        n_bucket = '0;
        for (int b = 1; b < HIST_BUCKETS; b++) begin
            if (w_ext >= (THR_W'(NS_PER_US) << b)) begin
                n_bucket = BW'(b);
            end
        end
    end

    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_data = {r_bucket, r_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= w_sample;
            r_bucket <= n_bucket;
        end
    end

endmodule

@@ rtl/lsh_fifo.sv @@
module lsh_fifo import lsh_pkg::*; #(
    parameter int DATA_W = SAMPLE_W,
    parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/lsh_back.sv @@
module lsh_back import lsh_pkg::*; #(
    parameter int HIST_BUCKETS = HIST_BUCKETS_DEF,
    parameter int SW           = SAMPLE_W,
    parameter int BW           = $clog2(HIST_BUCKETS_DEF)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  logic [SW+BW-1:0]    i_q_data,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [COUNT_W-1:0]  o_sample_count,
    output logic [TOTAL_W-1:0]  o_time_total,
    output logic [MEAN_W-1:0]   o_running_mean,
    output logic [M2_W-1:0]     o_squared_dev_sum,
    output logic [SAMPLE_W-1:0] o_least_sample,
    output logic [SAMPLE_W-1:0] o_greatest_sample,
    output logic [BUCKET_W-1:0] o_bucket_index,
    output logic [TALLY_W-1:0]  o_bucket_tally
);

    localparam int CNT_W = $clog2(DIV_ITERS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MEAN,
        ST_DEV,
        ST_MUL,
        ST_FIN
    } t_state;

    t_state r_state;

    logic [COUNT_W-1:0] r_count;
    logic [TOTAL_W-1:0] r_total;
    logic [MEAN_W-1:0]  r_mean;
    logic [M2_W-1:0]    r_m2;
    logic [SW-1:0]      r_min;
    logic [SW-1:0]      r_max;

    logic [MEAN_W-1:0]  r_sq;
    logic [MEAN_W-1:0]  r_mag;
    logic [MEAN_W-1:0]  r_mag2;
    logic               r_neg;
    logic [MEAN_W-1:0]  r_quo;
    logic [COUNT_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic [MEAN_W-1:0]  r_pp;
    logic [1:0]         r_pp_sh;
    logic [PROD_W-1:0]  r_prod;
    logic [BW-1:0]      r_bkt;
    logic [TALLY_W-1:0] r_tally;

    logic [TALLY_W-1:0]      r_hist [HIST_BUCKETS];
    logic [HIST_BUCKETS-1:0] r_hist_vld;
    logic [TALLY_W-1:0]      r_rd_data;
    logic                    r_rd_vld;

    logic               r_o_valid;
    logic [COUNT_W-1:0] r_o_count;
    logic [TOTAL_W-1:0] r_o_total;
    logic [MEAN_W-1:0]  r_o_mean;
    logic [M2_W-1:0]    r_o_m2;
    logic [SW-1:0]      r_o_min;
    logic [SW-1:0]      r_o_max;
    logic [BW-1:0]      r_o_bkt;
    logic [TALLY_W-1:0] r_o_tally;

    logic [SW-1:0]      w_sample;
    logic [BW-1:0]      w_bkt;
    logic [MEAN_W-1:0]  w_sq;
    logic               w_neg;
    logic [MEAN_W-1:0]  w_mag;
    logic [COUNT_W-1:0] n_count;
    logic [TOTAL_W:0]   w_tot_sum;
    logic [TOTAL_W-1:0] n_total;
    logic [COUNT_W-1:0] n_rem;
    logic [MEAN_W-1:0]  n_quo;
    logic [COUNT_W:0]   w_trial;
    logic [TALLY_W-1:0] w_tally_old;
    logic [TALLY_W-1:0] n_tally;
    logic [HALF_W-1:0]  w_pa;
    logic [HALF_W-1:0]  w_pb;
    logic [PROD_W-1:0]  w_pp_ext;
    logic [M2_W-1:0]    w_inc;
    logic [M2_W:0]      w_m2_sum;
    logic [M2_W-1:0]    n_m2;
    logic               w_slot_free;

    assign w_sample = i_q_data[SW-1:0];
    assign w_bkt    = i_q_data[SW+:BW];
    assign w_sq     = MEAN_W'(w_sample) << FRAC_W;
    assign w_neg    = (w_sq < r_mean);
    assign w_mag    = w_neg ? (r_mean - w_sq) : (w_sq - r_mean);

    assign n_count   = (r_count == '1) ? r_count : r_count + 1'b1;
    assign w_tot_sum = {1'b0, r_total} + (TOTAL_W + 1)'(w_sample);
    assign n_total   = w_tot_sum[TOTAL_W] ? '1 : w_tot_sum[TOTAL_W-1:0];

    // restoring division, two quotient bits per cycle
    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        w_trial = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            w_trial = {n_rem, n_quo[MEAN_W-1]};
            if (w_trial >= {1'b0, r_count}) begin
                w_trial = w_trial - {1'b0, r_count};
                n_quo   = {n_quo[MEAN_W-2:0], 1'b1};
            end else begin
                n_quo   = {n_quo[MEAN_W-2:0], 1'b0};
            end
            n_rem = w_trial[COUNT_W-1:0];
        end
    end

    assign w_tally_old = r_rd_vld ? r_rd_data : '0;
    assign n_tally     = (w_tally_old == '1) ? w_tally_old : w_tally_old + 1'b1;

    assign w_pa = r_cnt[1] ? r_mag[MEAN_W-1:HALF_W]  : r_mag[HALF_W-1:0];
    assign w_pb = r_cnt[0] ? r_mag2[MEAN_W-1:HALF_W] : r_mag2[HALF_W-1:0];

    always_comb begin
        case (r_pp_sh)
            2'd0:    w_pp_ext = PROD_W'(r_pp);
            2'd1:    w_pp_ext = PROD_W'(r_pp) << HALF_W;
            2'd2:    w_pp_ext = PROD_W'(r_pp) << (2 * HALF_W);
            default: w_pp_ext = '0;
        endcase
    end

    assign w_inc    = r_prod[HALF_W+M2_W-1:HALF_W];
    assign w_m2_sum = {1'b0, r_m2} + {1'b0, w_inc};
    assign n_m2     = ((|r_prod[PROD_W-1:HALF_W+M2_W]) || w_m2_sum[M2_W]) ? '1
                                                                      : w_m2_sum[M2_W-1:0];

    assign o_q_pop     = (r_state == ST_IDLE) && !i_q_empty;
    assign w_slot_free = !r_o_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_total    <= '0;
            r_mean     <= '0;
            r_m2       <= '0;
            r_min      <= '1;
            r_max      <= '0;
            r_hist_vld <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if ((r_state == ST_FIN) && w_slot_free) begin
                r_o_valid <= 1'b1;
            end else if (i_pop) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_count  <= n_count;
                        r_total  <= n_total;
                        r_min    <= (w_sample < r_min) ? w_sample : r_min;
                        r_max    <= (w_sample > r_max) ? w_sample : r_max;
                        r_sq     <= w_sq;
                        r_neg    <= w_neg;
                        r_mag    <= w_mag;
                        r_quo    <= w_mag;
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_bkt    <= w_bkt;
                        r_rd_vld <= r_hist_vld[w_bkt];
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_ITERS - 1)) begin
                        r_state <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    r_mean            <= r_neg ? (r_mean - r_quo) : (r_mean + r_quo);
                    r_tally           <= n_tally;
                    r_hist_vld[r_bkt] <= 1'b1;
                    r_state           <= ST_DEV;
                end
                ST_DEV: begin
                    r_mag2  <= r_neg ? (r_mean - r_sq) : (r_sq - r_mean);
                    r_prod  <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_cnt < CNT_W'(4)) begin
                        r_pp    <= w_pa * w_pb;
                        r_pp_sh <= 2'(r_cnt[1]) + 2'(r_cnt[0]);
                    end
                    if (r_cnt != '0) begin
                        r_prod <= r_prod + w_pp_ext;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(4)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_slot_free) begin
                        r_m2      <= n_m2;
                        r_o_count <= r_count;
                        r_o_total <= r_total;
                        r_o_mean  <= r_mean;
                        r_o_m2    <= n_m2;
                        r_o_min   <= r_min;
                        r_o_max   <= r_max;
                        r_o_bkt   <= r_bkt;
                        r_o_tally <= r_tally;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd_data <= r_hist[w_bkt];
        end
        if (r_state == ST_MEAN) begin
            r_hist[r_bkt] <= n_tally;
        end
    end

    assign o_empty           = !r_o_valid;
    assign o_sample_count    = r_o_count;
    assign o_time_total      = r_o_total;
    assign o_running_mean    = r_o_mean;
    assign o_squared_dev_sum = r_o_m2;
    assign o_least_sample    = SAMPLE_W'(r_o_min);
    assign o_greatest_sample = SAMPLE_W'(r_o_max);
    assign o_bucket_index    = BUCKET_W'(r_o_bkt);
    assign o_bucket_tally    = r_o_tally;

endmodule

@@ rtl/latency_stats_log2_histogram_top.sv @@
// Latency statistics engine: push one duration in ns per item, pop one result per item
// carrying the sample count, saturating sum, min, max, Welford running mean (Q48.16),
// saturating M2 and the log2 microsecond histogram bucket with its updated tally. The
// front classifies the bucket combinationally and buffers up to three items; the back
// takes one item at a time: it issues the item, runs the radix-4 serial mean divider
// (64-bit dividend by 32-bit count), updates the mean, forms the second deviation,
// runs the 4-pass 32x32 product and folds it into M2. The divider sets the sustained
// rate when results are popped promptly. The histogram clears at reset through
// per-bucket valid bits, so the block is ready in the cycle after reset.
module latency_stats_log2_histogram_top import lsh_pkg::*; #(
    parameter int HIST_BUCKETS = HIST_BUCKETS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [SAMPLE_W-1:0] i_sample_ns,
    output logic                empty,
    input  logic                pop,
    output logic [COUNT_W-1:0]  o_sample_count,
    output logic [TOTAL_W-1:0]  o_time_total,
    output logic [MEAN_W-1:0]   o_running_mean,
    output logic [M2_W-1:0]     o_squared_dev_sum,
    output logic [SAMPLE_W-1:0] o_least_sample,
    output logic [SAMPLE_W-1:0] o_greatest_sample,
    output logic [BUCKET_W-1:0] o_bucket_index,
    output logic [TALLY_W-1:0]  o_bucket_tally
);

    localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int BW = $clog2(HIST_BUCKETS);
    localparam int QW = SW + BW;

    logic          w_q_push;
    logic          w_q_full;
    logic [QW-1:0] w_q_wdata;
    logic          w_q_pop;
    logic          w_q_empty;
    logic [QW-1:0] w_q_rdata;

    lsh_front #(
        .HIST_BUCKETS (HIST_BUCKETS),
        .SW           (SW),
        .BW           (BW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_sample_ns (i_sample_ns),
        .o_full      (full),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_wdata),
        .i_q_full    (w_q_full)
    );

    lsh_fifo #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH_DEF)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    lsh_back #(
        .HIST_BUCKETS (HIST_BUCKETS),
        .SW           (SW),
        .BW           (BW)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (w_q_empty),
        .i_q_data          (w_q_rdata),
        .o_q_pop           (w_q_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_sample_count    (o_sample_count),
        .o_time_total      (o_time_total),
        .o_running_mean    (o_running_mean),
        .o_squared_dev_sum (o_squared_dev_sum),
        .o_least_sample    (o_least_sample),
        .o_greatest_sample (o_greatest_sample),
        .o_bucket_index    (o_bucket_index),
        .o_bucket_tally    (o_bucket_tally)
    );

endmodule

@@ tb/latency_stats_log2_histogram_top_test.sv @@
module latency_stats_log2_histogram_top_test;
    import lsh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 500_000;
    localparam int TAIL_CYCLES = 60;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [TOTAL_W-1:0]  total;
        logic [MEAN_W-1:0]   mean;
        logic [M2_W-1:0]     m2;
        logic [SAMPLE_W-1:0] least;
        logic [SAMPLE_W-1:0] greatest;
        logic [BUCKET_W-1:0] bucket;
        logic [TALLY_W-1:0]  tally;
    } t_stats;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic [SAMPLE_W-1:0] i_sample_ns;
    logic                empty;
    logic                pop;
    logic [COUNT_W-1:0]  o_sample_count;
    logic [TOTAL_W-1:0]  o_time_total;
    logic [MEAN_W-1:0]   o_running_mean;
    logic [M2_W-1:0]     o_squared_dev_sum;
    logic [SAMPLE_W-1:0] o_least_sample;
    logic [SAMPLE_W-1:0] o_greatest_sample;
    logic [BUCKET_W-1:0] o_bucket_index;
    logic [TALLY_W-1:0]  o_bucket_tally;

    logic [COUNT_W-1:0]  acc_count;
    logic [TOTAL_W-1:0]  acc_total;
    logic [MEAN_W-1:0]   acc_mean;
    logic [M2_W-1:0]     acc_m2;
    logic [SAMPLE_W-1:0] acc_min;
    logic [SAMPLE_W-1:0] acc_max;
    logic [TALLY_W-1:0]  acc_buckets [HIST_BUCKETS_DEF];

    t_stats              pending_stats [$];
    logic [SAMPLE_W-1:0] last_sample;
    int                  cycle_count = 0;
    int                  error_count = 0;
    int                  items_sent = 0;
    int                  results_checked = 0;
    int                  full_stall_cycles = 0;
    int                  tx_gap_max = 0;
    int                  tx_burst_max = 1;
    int                  burst_left = 0;
    bit                  rx_stall_on = 0;
    int                  rx_hold_req = 0;

    latency_stats_log2_histogram_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_sample_ns       (i_sample_ns),
        .empty             (empty),
        .pop               (pop),
        .o_sample_count    (o_sample_count),
        .o_time_total      (o_time_total),
        .o_running_mean    (o_running_mean),
        .o_squared_dev_sum (o_squared_dev_sum),
        .o_least_sample    (o_least_sample),
        .o_greatest_sample (o_greatest_sample),
        .o_bucket_index    (o_bucket_index),
        .o_bucket_tally    (o_bucket_tally)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < RUN_LIMIT) @(posedge i_clk);
        $display("latency_stats_log2_histogram_top_test failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (error_count < PRINT_CAP) $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic int bucket_of(input logic [SAMPLE_W-1:0] ns);
        logic [SAMPLE_W-1:0] us;
        int b;
        us = ns / NS_PER_US;
        if (us < 1) us = 1;
        b = 0;
        while (us > 1 && b < HIST_BUCKETS_DEF - 1) begin
            us = us >> 1;
            b++;
        end
        return b;
    endfunction

    function automatic t_stats fold_sample(input logic [SAMPLE_W-1:0] ns);
        logic [MEAN_W-1:0]  scaled;
        logic [MEAN_W-1:0]  mag;
        logic [MEAN_W-1:0]  mag2;
        logic [PROD_W-1:0]  prod;
        logic [M2_W-1:0]    prod_int;
        logic [TOTAL_W:0]   sum;
        int                 b;
        t_stats             r;
        scaled = {ns, {FRAC_W{1'b0}}};
        if (acc_count != '1) acc_count = acc_count + 1;
        sum = {1'b0, acc_total} + ns;
        acc_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        if (scaled >= acc_mean) begin
            mag = scaled - acc_mean;
            acc_mean = acc_mean + mag / MEAN_W'(acc_count);
            mag2 = scaled - acc_mean;
        end else begin
            mag = acc_mean - scaled;
            acc_mean = acc_mean - mag / MEAN_W'(acc_count);
            mag2 = acc_mean - scaled;
        end
        prod = PROD_W'(mag) * PROD_W'(mag2);
        if (prod[PROD_W-1:PROD_W-HALF_W] != 0) prod_int = '1;
        else prod_int = prod[PROD_W-HALF_W-1:HALF_W];
        if (acc_m2 > ~prod_int) acc_m2 = '1;
        else acc_m2 = acc_m2 + prod_int;
        if (ns < acc_min) acc_min = ns;
        if (ns > acc_max) acc_max = ns;
        b = bucket_of(ns);
        if (acc_buckets[b] != '1) acc_buckets[b] = acc_buckets[b] + 1;
        r.count    = acc_count;
        r.total    = acc_total;
        r.mean     = acc_mean;
        r.m2       = acc_m2;
        r.least    = acc_min;
        r.greatest = acc_max;
        r.bucket   = BUCKET_W'(b);
        r.tally    = acc_buckets[b];
        return r;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] ns);
        int gap;
        push <= 1'b1;
        i_sample_ns <= ns;
        do begin
            @(posedge i_clk);
            if (full !== 1'b0) full_stall_cycles++;
        end while (full !== 1'b0);
        pending_stats.insert(pending_stats.size(), fold_sample(ns));
        last_sample = ns;
        items_sent++;
        if (tx_gap_max > 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, tx_burst_max);
                gap = $urandom_range(1, tx_gap_max);
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_results;
        push <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_stats.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) flag_error($sformatf("%s: expected %h, got %h", name, want, got));
    endtask

    task automatic check_result;
        t_stats want;
        results_checked++;
        if (pending_stats.size() == 0) begin
            flag_error("result popped with no item outstanding");
            return;
        end
        want = pending_stats.pop_front();
        check_field("sample_count", 64'(want.count), 64'(o_sample_count));
        check_field("time_total", 64'(want.total), 64'(o_time_total));
        check_field("running_mean", want.mean, o_running_mean);
        check_field("squared_dev_sum", want.m2, o_squared_dev_sum);
        check_field("least_sample", 64'(want.least), 64'(o_least_sample));
        check_field("greatest_sample", 64'(want.greatest), 64'(o_greatest_sample));
        check_field("bucket_index", 64'(want.bucket), 64'(o_bucket_index));
        check_field("bucket_tally", 64'(want.tally), 64'(o_bucket_tally));
    endtask

    initial begin
        logic [15:0] pattern;
        int          pattern_age;
        int          hold_left;
        pattern = '1;
        pattern_age = 0;
        hold_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) check_result();
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (i_rst_n !== 1'b1) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_stall_on) begin
                if (pattern_age == 0) begin
                    pattern = 16'($urandom);
                    if (pattern == 0) pattern = 16'h0001;
                    pattern_age = $urandom_range(8, 80);
                end
                pattern_age--;
                pop <= pattern[0];
                pattern = {pattern[0], pattern[15:1]};
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] draw_moderate_ns();
        int                  w;
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 15))
            0: v = (SAMPLE_W'(NS_PER_US) << $urandom_range(0, 17)) - $urandom_range(0, 1);
            1: v = last_sample;
            default: begin
                w = $urandom_range(1, 27);
                v = SAMPLE_W'({$urandom, $urandom}) & ((SAMPLE_W'(1) << w) - 1);
            end
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_wide_ns();
        int                  w;
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 15))
            0: v = (SAMPLE_W'(NS_PER_US) << $urandom_range(18, 32)) - $urandom_range(0, 1);
            1: v = '1;
            default: begin
                w = $urandom_range(1, SAMPLE_W);
                v = SAMPLE_W'({$urandom, $urandom});
                if (w < SAMPLE_W) v = v & ((SAMPLE_W'(1) << w) - 1);
            end
        endcase
        return v;
    endfunction

    task automatic test_small_durations;
        logic [SAMPLE_W-1:0] picks [$] = '{
            48'd0, 48'd0, 48'd1, 48'd500, 48'd999, 48'd1000, 48'd1001, 48'd1999,
            48'd2000, 48'd3999, 48'd4000, 48'd4000, 48'd4001, 48'd7999, 48'd8000,
            48'd16383999, 48'd16384000
        };
        tx_gap_max = 0;
        rx_stall_on = 0;
        foreach (picks[i]) send_sample(picks[i]);
        wait_for_results();
    endtask

    task automatic test_idle_mixes;
        for (int phase = 0; phase < 4; phase++) begin
            tx_gap_max = phase[0] ? 30 : 0;
            tx_burst_max = 8;
            rx_stall_on = phase[1];
            repeat (160) send_sample(draw_moderate_ns());
            wait_for_results();
        end
    endtask

    task automatic test_full_backpressure;
        tx_gap_max = 0;
        rx_stall_on = 0;
        rx_hold_req = 400;
        @(posedge i_clk);
        repeat (30) send_sample(draw_moderate_ns());
        wait_for_results();
    endtask

    task automatic test_wide_samples;
        logic [SAMPLE_W-1:0] picks [$] = '{
            48'hFFFF_FFFF_FFFF, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
            48'd2147483647999, 48'd2147483648000, 48'd1073741823999, 48'd0
        };
        tx_gap_max = 0;
        rx_stall_on = 0;
        foreach (picks[i]) send_sample(picks[i]);
        tx_gap_max = 20;
        tx_burst_max = 6;
        rx_stall_on = 1;
        repeat (150) send_sample(draw_wide_ns());
        wait_for_results();
    endtask

    initial begin
        int buckets_hit;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_sample_ns <= '0;
        acc_count = '0;
        acc_total = '0;
        acc_mean = '0;
        acc_m2 = '0;
        acc_min = '1;
        acc_max = '0;
        last_sample = '0;
        foreach (acc_buckets[i]) acc_buckets[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_durations();
        test_idle_mixes();
        test_full_backpressure();
        test_wide_samples();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_stats.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_stats.size()));
        buckets_hit = 0;
        foreach (acc_buckets[i]) if (acc_buckets[i] != 0) buckets_hit++;
        $display("covered %0d samples, %0d results checked, %0d cycles of input held by full",
                 items_sent, results_checked, full_stall_cycles);
        $display("histogram buckets reached: %0d of %0d, M2 saturated at end: %0d",
                 buckets_hit, HIST_BUCKETS_DEF, acc_m2 == '1);
        if (error_count == 0) begin
            $display("latency_stats_log2_histogram_top_test passed");
        end else begin
            $display("latency_stats_log2_histogram_top_test failed");
        end
        $finish;
    end

endmodule
